// ===== rtl/assert_macros.svh =====
// Assertion macros used by broadcast_strided_offset.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/bso_pkg.sv =====
// Package of the broadcast strided offset block: widths, codes, defaults.
// No dependencies.
package bso_pkg;
   localparam int IDX_W     = 63;
   localparam int OFF_W     = 35;
   localparam int CNT_W     = 64;
   localparam int CFG_W     = 64;
   localparam int BASE_W    = 32;
   localparam int OPC_W     = 2;
   localparam int CSR_IDX_W = 3;

   localparam int MAX_RANK_DEF     = 4;
   localparam int DIM_BITS_DEF     = 16;
   localparam int NUM_OPERANDS_DEF = 2;

   localparam logic [CFG_W-1:0] RESET_SHAPE = 64'h0001_0001_0001_0001;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SHAPE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OPERAND_COUNT = 3'd0,
      REG_SHAPE_A       = 3'd1,
      REG_SHAPE_B       = 3'd2,
      REG_STRIDE_A      = 3'd3,
      REG_STRIDE_B      = 3'd4,
      REG_BASE_A        = 3'd5,
      REG_BASE_B        = 3'd6
   } csr_reg_type;
endpackage

// ===== rtl/broadcast_strided_offset.sv =====
// Broadcast strided offset generator: one item per cycle in and out unless
// req_stall or rsp_stall holds it; each dimension has a 63-stage restoring
// divider (one quotient bit per stage) plus its stride multiply stage.
// A two-entry output queue lets the pipeline keep going while a result waits.
// Derived shape data is registered in bso_shape after a register write.
module broadcast_strided_offset #(
   parameter int MAX_RANK     = bso_pkg::MAX_RANK_DEF,
   parameter int DIM_BITS     = bso_pkg::DIM_BITS_DEF,
   parameter int NUM_OPERANDS = bso_pkg::NUM_OPERANDS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_operand,
   input  logic [bso_pkg::IDX_W-1:0]       req_flat_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bso_pkg::OFF_W-1:0]       rsp_offset,
   output logic [bso_pkg::CNT_W-1:0]       rsp_element_count,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_we,
   input  logic [bso_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bso_pkg::CFG_W-1:0]       csr_wdata
);
   import bso_pkg::*;
   `include "assert_macros.svh"

   localparam int PW    = 2 * DIM_BITS;
   localparam int SUM_W = (PW > OFF_W) ? PW : OFF_W;

   // configuration registers
   logic [OPC_W-1:0]  opc_ff;
   logic [CFG_W-1:0]  shape_a_ff, shape_b_ff, stride_a_ff, stride_b_ff;
   logic [BASE_W-1:0] base_a_ff, base_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opc_ff      <= OPC_W'(1);
         shape_a_ff  <= RESET_SHAPE;
         shape_b_ff  <= RESET_SHAPE;
         stride_a_ff <= '0;
         stride_b_ff <= '0;
         base_a_ff   <= '0;
         base_b_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_OPERAND_COUNT: opc_ff      <= csr_wdata[OPC_W-1:0];
            REG_SHAPE_A:       shape_a_ff  <= csr_wdata;
            REG_SHAPE_B:       shape_b_ff  <= csr_wdata;
            REG_STRIDE_A:      stride_a_ff <= csr_wdata;
            REG_STRIDE_B:      stride_b_ff <= csr_wdata;
            REG_BASE_A:        base_a_ff   <= csr_wdata[BASE_W-1:0];
            REG_BASE_B:        base_b_ff   <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   logic [MAX_RANK-1:0][DIM_BITS-1:0] bshape, st0, st1;
   logic                              two_ops, bad;
   logic [CNT_W-1:0]                  count;

   bso_shape #(
      .MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS), .NUM_OPERANDS(NUM_OPERANDS)
   ) u_shape (
      .clock(clock), .operand_count(opc_ff),
      .shape_a(shape_a_ff), .shape_b(shape_b_ff),
      .stride_a(stride_a_ff), .stride_b(stride_b_ff),
      .bshape(bshape), .stride0(st0), .stride1(st1),
      .two_ops(two_ops), .bad(bad), .count(count)
   );

   // pipeline advances while the skid slot is empty
   logic skid_valid_ff;
   logic en, accept;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && en;

   logic             e_valid_ff, e_op_ff;
   logic [IDX_W-1:0] e_idx_ff;
   logic [OFF_W-1:0] e_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= accept;
      end
      if (accept) begin
         e_op_ff  <= req_operand;
         e_idx_ff <= req_flat_index;
         e_acc_ff <= OFF_W'(req_operand ? base_b_ff : base_a_ff);
      end
   end

   logic             ch_valid [MAX_RANK+1];
   logic             ch_op    [MAX_RANK+1];
   logic [IDX_W-1:0] ch_idx   [MAX_RANK+1];
   logic [IDX_W-1:0] ch_q     [MAX_RANK+1];
   logic [OFF_W-1:0] ch_acc   [MAX_RANK+1];
   logic [PW-1:0]    ch_prod  [MAX_RANK+1];

   assign ch_valid[0] = e_valid_ff;
   assign ch_op[0]    = e_op_ff;
   assign ch_idx[0]   = e_idx_ff;
   assign ch_q[0]     = e_idx_ff;
   assign ch_acc[0]   = e_acc_ff;
   assign ch_prod[0]  = '0;

   for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
      bso_dim #(.DIM_BITS(DIM_BITS)) u_dim (
         .clock(clock), .reset(reset), .en(en),
         .divisor(bshape[d]), .stride0(st0[d]), .stride1(st1[d]),
         .in_valid(ch_valid[d]), .in_op(ch_op[d]), .in_idx(ch_idx[d]),
         .in_q(ch_q[d]), .in_acc(ch_acc[d]), .in_prod(ch_prod[d]),
         .out_valid(ch_valid[d+1]), .out_op(ch_op[d+1]), .out_idx(ch_idx[d+1]),
         .out_q(ch_q[d+1]), .out_acc(ch_acc[d+1]), .out_prod(ch_prod[d+1])
      );
   end

   // final checks and last accumulate
   logic [SUM_W-1:0] fin_sum;
   logic [OFF_W-1:0] fin_offset;
   logic [CNT_W-1:0] fin_count;
   status_type       fin_status;
   logic             op_ok;

   assign fin_sum = SUM_W'(ch_acc[MAX_RANK]) + SUM_W'(ch_prod[MAX_RANK]);
   assign op_ok   = !ch_op[MAX_RANK] || two_ops;

   always_comb begin
      if (bad) begin
         fin_status = ST_SHAPE;
         fin_count  = '0;
         fin_offset = '0;
      end else if (!op_ok || (CNT_W'(ch_idx[MAX_RANK]) >= count)) begin
         fin_status = ST_RANGE;
         fin_count  = count;
         fin_offset = '0;
      end else begin
         fin_status = ST_OK;
         fin_count  = count;
         fin_offset = fin_sum[OFF_W-1:0];
      end
   end

   // output register plus skid slot
   logic             rsp_valid_ff;
   logic [OFF_W-1:0] rsp_offset_ff, skid_offset_ff;
   logic [CNT_W-1:0] rsp_count_ff, skid_count_ff;
   status_type       rsp_status_ff, skid_status_ff;
   logic             pop, push;

   assign pop  = rsp_valid_ff && !rsp_stall;
   assign push = en && ch_valid[MAX_RANK];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (skid_valid_ff && pop) begin
         rsp_offset_ff <= skid_offset_ff;
         rsp_count_ff  <= skid_count_ff;
         rsp_status_ff <= skid_status_ff;
      end else if (push && (!rsp_valid_ff || pop)) begin
         rsp_offset_ff <= fin_offset;
         rsp_count_ff  <= fin_count;
         rsp_status_ff <= fin_status;
      end
      if (push && rsp_valid_ff && !pop) begin
         skid_offset_ff <= fin_offset;
         skid_count_ff  <= fin_count;
         skid_status_ff <= fin_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_offset        = rsp_offset_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   `ASSERT_IMPLIES(a_skid_has_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, rsp_valid_ff && !skid_valid_ff)
   `ASSERT_IMPLIES(a_err_zero_offset, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_offset_ff == '0)
   `ASSERT_IMPLIES(a_shape_zero_count, clock, reset, rsp_valid_ff && (rsp_status_ff == ST_SHAPE), rsp_count_ff == '0)
endmodule

// ===== rtl/bso_shape.sv =====
// Broadcast shape, compatibility, effective strides and element count,
// derived from the configuration registers. Depends on bso_pkg.
module bso_shape #(
   parameter int MAX_RANK     = bso_pkg::MAX_RANK_DEF,
   parameter int DIM_BITS     = bso_pkg::DIM_BITS_DEF,
   parameter int NUM_OPERANDS = bso_pkg::NUM_OPERANDS_DEF
) (
   input  logic                               clock,
   input  logic [bso_pkg::OPC_W-1:0]          operand_count,
   input  logic [bso_pkg::CFG_W-1:0]          shape_a,
   input  logic [bso_pkg::CFG_W-1:0]          shape_b,
   input  logic [bso_pkg::CFG_W-1:0]          stride_a,
   input  logic [bso_pkg::CFG_W-1:0]          stride_b,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  bshape,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  stride0,
   output logic [MAX_RANK-1:0][DIM_BITS-1:0]  stride1,
   output logic                               two_ops,
   output logic                               bad,
   output logic [bso_pkg::CNT_W-1:0]          count
);
   import bso_pkg::*;

   localparam logic [DIM_BITS-1:0] ONE  = DIM_BITS'(1);
   localparam logic [DIM_BITS-1:0] ZERO = '0;
   localparam int PW = CNT_W + DIM_BITS;

   function automatic logic [DIM_BITS-1:0] field(input logic [CFG_W-1:0] r, input int d,
                                                 input logic [DIM_BITS-1:0] beyond);
      logic [CFG_W-1:0] sh;
      if (d * DIM_BITS >= CFG_W) return beyond;
      sh = r >> (d * DIM_BITS);
      return sh[DIM_BITS-1:0];
   endfunction

   logic                              two_in, two_ff;
   logic [MAX_RANK-1:0]               bad_in;
   logic                              bad_ff;
   logic [MAX_RANK-1:0][DIM_BITS-1:0] bshape_in, bshape_ff;
   logic [MAX_RANK-1:0][DIM_BITS-1:0] st0_in, st0_ff, st1_in, st1_ff;

   assign two_in = (NUM_OPERANDS >= 2) && operand_count[1];

   always_comb begin
      logic [DIM_BITS-1:0] sa, sb;
      for (int d = 0; d < MAX_RANK; d++) begin
         sa = field(shape_a, d, ONE);
         sb = field(shape_b, d, ONE);
         st0_in[d] = (sa == ONE) ? ZERO : field(stride_a, d, ZERO);
         st1_in[d] = (sb == ONE) ? ZERO : field(stride_b, d, ZERO);
         if (two_in) begin
            bad_in[d]    = (sa != ONE) && (sb != ONE) && (sa != sb);
            bshape_in[d] = (sa == ONE) ? sb : sa;
         end else begin
            bad_in[d]    = 1'b0;
            bshape_in[d] = sa;
         end
      end
   end

   always_ff @(posedge clock) begin
      two_ff    <= two_in;
      bad_ff    <= |bad_in;
      bshape_ff <= bshape_in;
      st0_ff    <= st0_in;
      st1_ff    <= st1_in;
   end

   // running product, one dimension per register stage
   logic [CNT_W-1:0] c_ff [MAX_RANK];
   logic             z_ff [MAX_RANK];
   logic             s_ff [MAX_RANK];

   for (genvar d = 0; d < MAX_RANK; d++) begin : g_cnt
      logic [CNT_W-1:0] c_prev;
      logic             z_prev, s_prev;
      logic [PW-1:0]    full;
      if (d == 0) begin : g_first
         assign c_prev = CNT_W'(1);
         assign z_prev = 1'b0;
         assign s_prev = 1'b0;
      end else begin : g_next
         assign c_prev = c_ff[d-1];
         assign z_prev = z_ff[d-1];
         assign s_prev = s_ff[d-1];
      end
      assign full = PW'(c_prev) * PW'(bshape_ff[d]);
      always_ff @(posedge clock) begin
         c_ff[d] <= full[CNT_W-1:0];
         z_ff[d] <= z_prev || (bshape_ff[d] == ZERO);
         s_ff[d] <= s_prev || (|full[PW-1:CNT_W]);
      end
   end

   assign bshape  = bshape_ff;
   assign stride0 = st0_ff;
   assign stride1 = st1_ff;
   assign two_ops = two_ff;
   assign bad     = bad_ff;
   assign count   = z_ff[MAX_RANK-1] ? '0 : (s_ff[MAX_RANK-1] ? '1 : c_ff[MAX_RANK-1]);
endmodule

// ===== rtl/bso_dim.sv =====
// One dimension: pipelined restoring divider, one quotient bit per stage,
// then coordinate times stride. Depends on bso_pkg.
module bso_dim #(
   parameter int DIM_BITS = bso_pkg::DIM_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [DIM_BITS-1:0]         divisor,
   input  logic [DIM_BITS-1:0]         stride0,
   input  logic [DIM_BITS-1:0]         stride1,
   input  logic                        in_valid,
   input  logic                        in_op,
   input  logic [bso_pkg::IDX_W-1:0]   in_idx,
   input  logic [bso_pkg::IDX_W-1:0]   in_q,
   input  logic [bso_pkg::OFF_W-1:0]   in_acc,
   input  logic [2*DIM_BITS-1:0]       in_prod,
   output logic                        out_valid,
   output logic                        out_op,
   output logic [bso_pkg::IDX_W-1:0]   out_idx,
   output logic [bso_pkg::IDX_W-1:0]   out_q,
   output logic [bso_pkg::OFF_W-1:0]   out_acc,
   output logic [2*DIM_BITS-1:0]       out_prod
);
   import bso_pkg::*;

   localparam int STEPS = IDX_W;
   localparam int PW    = 2 * DIM_BITS;
   localparam int SUM_W = (PW > OFF_W) ? PW : OFF_W;

   logic               v_ff   [STEPS];
   logic               op_ff  [STEPS];
   logic [IDX_W-1:0]   idx_ff [STEPS];
   logic [IDX_W-1:0]   q_ff   [STEPS];
   logic [DIM_BITS-1:0] r_ff  [STEPS];
   logic [OFF_W-1:0]   acc_ff [STEPS];

   logic [SUM_W-1:0] sum0;
   assign sum0 = SUM_W'(in_acc) + SUM_W'(in_prod);

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic                v_src, op_src;
      logic [IDX_W-1:0]    idx_src, q_src;
      logic [DIM_BITS-1:0] r_src;
      logic [OFF_W-1:0]    acc_src;
      logic [DIM_BITS:0]   t, diff;
      logic                ge;
      if (j == 0) begin : g_first
         assign v_src   = in_valid;
         assign op_src  = in_op;
         assign idx_src = in_idx;
         assign q_src   = in_q;
         assign r_src   = '0;
         assign acc_src = sum0[OFF_W-1:0];
      end else begin : g_next
         assign v_src   = v_ff[j-1];
         assign op_src  = op_ff[j-1];
         assign idx_src = idx_ff[j-1];
         assign q_src   = q_ff[j-1];
         assign r_src   = r_ff[j-1];
         assign acc_src = acc_ff[j-1];
      end
      assign t    = {r_src, q_src[IDX_W-1]};
      assign ge   = t >= {1'b0, divisor};
      assign diff = t - {1'b0, divisor};
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en) begin
            v_ff[j] <= v_src;
         end
         if (en) begin
            op_ff[j]  <= op_src;
            idx_ff[j] <= idx_src;
            q_ff[j]   <= {q_src[IDX_W-2:0], ge};
            r_ff[j]   <= ge ? diff[DIM_BITS-1:0] : t[DIM_BITS-1:0];
            acc_ff[j] <= acc_src;
         end
      end
   end

   logic                v_m_ff, op_m_ff;
   logic [IDX_W-1:0]    idx_m_ff, q_m_ff;
   logic [OFF_W-1:0]    acc_m_ff;
   logic [PW-1:0]       prod_m_ff;
   logic [DIM_BITS-1:0] st;

   assign st = op_ff[STEPS-1] ? stride1 : stride0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_m_ff <= 1'b0;
      end else if (en) begin
         v_m_ff <= v_ff[STEPS-1];
      end
      if (en) begin
         op_m_ff   <= op_ff[STEPS-1];
         idx_m_ff  <= idx_ff[STEPS-1];
         q_m_ff    <= q_ff[STEPS-1];
         acc_m_ff  <= acc_ff[STEPS-1];
         prod_m_ff <= PW'(r_ff[STEPS-1]) * PW'(st);
      end
   end

   assign out_valid = v_m_ff;
   assign out_op    = op_m_ff;
   assign out_idx   = idx_m_ff;
   assign out_q     = q_m_ff;
   assign out_acc   = acc_m_ff;
   assign out_prod  = prod_m_ff;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for broadcast_strided_offset: directed table, then
// random register settings with random items, checked against a predictor.
// Depends on bso_pkg and the broadcast_strided_offset RTL.
`timescale 1ns / 1ps

module tb;
   import bso_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 700;
   localparam int RAND_PHASES = 10;
   localparam int PHASE_ITEMS = 160;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_operand;
   logic [IDX_W-1:0] req_flat_index;
   logic rsp_valid;
   logic rsp_stall;
   logic [OFF_W-1:0] rsp_offset;
   logic [CNT_W-1:0] rsp_element_count;
   logic [1:0] rsp_status;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   broadcast_strided_offset uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operand(req_operand), .req_flat_index(req_flat_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_offset(rsp_offset), .rsp_element_count(rsp_element_count),
      .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct {
      logic [OFF_W-1:0] offset;
      logic [CNT_W-1:0] count;
      logic [1:0] status;
   } addr_result_type;

   typedef struct {
      bit cfg;
      csr_reg_type reg_id;
      logic [CFG_W-1:0] value;
      logic operand;
      logic [IDX_W-1:0] index;
      bit typed;
      addr_result_type result;
   } stim_row_type;

   addr_result_type pending_addrs[$];
   stim_row_type rows[$];
   logic [1:0] op_count;
   logic [63:0] shapes[2];
   logic [63:0] strides[2];
   logic [31:0] bases[2];
   int mismatches;
   int cycles;
   bit calm;
   bit hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void predict_addr(input logic op, input logic [IDX_W-1:0] idx,
                                        output addr_result_type res);
      logic [15:0] bshape[MAX_RANK_DEF];
      logic [15:0] s;
      logic [63:0] st;
      logic [127:0] prod;
      logic [63:0] cnt, rem, acc;
      int n;
      bit bad;
      n = (op_count == 2'd0) ? 1 : ((op_count == 2'd1) ? 1 : 2);
      bad = 1'b0;
      for (int d = 0; d < MAX_RANK_DEF; d++) begin
         bshape[d] = 16'd1;
         for (int k = 0; k < n; k++) begin
            s = shapes[k][d*16 +: 16];
            if (bshape[d] != 16'd1 && s != 16'd1 && bshape[d] != s) bad = 1'b1;
            if (bshape[d] == 16'd1) bshape[d] = s;
         end
      end
      res.offset = '0;
      res.count = '0;
      res.status = ST_SHAPE;
      if (bad) return;
      cnt = 64'd1;
      for (int d = 0; d < MAX_RANK_DEF; d++) begin
         if (bshape[d] == 16'd0) begin
            cnt = 64'd0;
            break;
         end
         prod = cnt * bshape[d];
         cnt = (prod[127:64] != 0) ? '1 : prod[63:0];
      end
      res.count = cnt;
      if (int'(op) >= n || {1'b0, idx} >= cnt) begin
         res.status = ST_RANGE;
         return;
      end
      rem = {1'b0, idx};
      acc = {32'd0, bases[op]};
      for (int d = 0; d < MAX_RANK_DEF; d++) begin
         st = (shapes[op][d*16 +: 16] == 16'd1) ? 64'd0 : {48'd0, strides[op][d*16 +: 16]};
         acc = acc + (rem % bshape[d]) * st;
         rem = rem / bshape[d];
      end
      res.offset = acc[OFF_W-1:0];
      res.status = ST_OK;
   endfunction

   always @(posedge clock) begin
      addr_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_addrs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: off %0h cnt %0h st %0d",
               rsp_offset, rsp_element_count, rsp_status);
         end else begin
            exp_r = pending_addrs.pop_front();
            if (rsp_offset !== exp_r.offset || rsp_element_count !== exp_r.count ||
                rsp_status !== exp_r.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp off %0h cnt %0h st %0d, got off %0h cnt %0h st %0d",
                     exp_r.offset, exp_r.count, exp_r.status,
                     rsp_offset, rsp_element_count, rsp_status);
            end
         end
      end
   end

   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            @(negedge clock);
         end
      end
   end

   function automatic void add_row(input stim_row_type row);
      rows.insert(rows.size(), row);
   endfunction

   task automatic drain_items();
      req_valid <= 1'b0;
      while (pending_addrs.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [CFG_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (r)
         REG_OPERAND_COUNT: op_count = v[1:0];
         REG_SHAPE_A:       shapes[0] = v;
         REG_SHAPE_B:       shapes[1] = v;
         REG_STRIDE_A:      strides[0] = v;
         REG_STRIDE_B:      strides[1] = v;
         REG_BASE_A:        bases[0] = v[31:0];
         REG_BASE_B:        bases[1] = v[31:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic op, input logic [IDX_W-1:0] idx, input bit typed,
                            input addr_result_type typed_r);
      addr_result_type r;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operand <= op;
      req_flat_index <= idx;
      do @(posedge clock); while (req_stall);
      if (typed) r = typed_r;
      else predict_addr(op, idx, r);
      pending_addrs.insert(pending_addrs.size(), r);
      @(negedge clock);
   endtask

   function automatic stim_row_type cfg_row(input csr_reg_type r, input logic [63:0] v);
      stim_row_type row;
      row.cfg = 1'b1;
      row.reg_id = r;
      row.value = v;
      row.operand = 1'b0;
      row.index = '0;
      row.typed = 1'b0;
      row.result.offset = '0;
      row.result.count = '0;
      row.result.status = ST_OK;
      return row;
   endfunction

   function automatic stim_row_type item_row(input logic op, input logic [IDX_W-1:0] idx,
                                             input bit typed, input logic [OFF_W-1:0] off,
                                             input logic [63:0] cnt, input status_type st);
      stim_row_type row;
      row.cfg = 1'b0;
      row.reg_id = REG_OPERAND_COUNT;
      row.value = '0;
      row.operand = op;
      row.index = idx;
      row.typed = typed;
      row.result.offset = off;
      row.result.count = cnt;
      row.result.status = st;
      return row;
   endfunction

   function automatic logic [15:0] rand_dim();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 16'd0;
      if (sel == 1) return 16'hFFFF;
      if (sel < 6) return 16'd1;
      return 16'($urandom_range(2, 7));
   endfunction

   task automatic random_config();
      logic [63:0] sa, sb;
      logic [15:0] da;
      for (int d = 0; d < 4; d++) begin
         da = rand_dim();
         sa[d*16 +: 16] = da;
         case ($urandom_range(0, 9))
            0, 1, 2: sb[d*16 +: 16] = da;
            3, 4, 5: sb[d*16 +: 16] = 16'd1;
            6:       sb[d*16 +: 16] = 16'($urandom);
            default: sb[d*16 +: 16] = (da == 16'd1) ? rand_dim() : da;
         endcase
         if (sa[d*16 +: 16] == 16'd0 && $urandom_range(0, 3) != 0) sa[d*16 +: 16] = 16'd3;
         if (sb[d*16 +: 16] == 16'd0 && $urandom_range(0, 3) != 0) sb[d*16 +: 16] = 16'd1;
      end
      if ($urandom_range(0, 15) == 0) sa = {$urandom, $urandom};
      write_reg(REG_OPERAND_COUNT, {$urandom, $urandom});
      write_reg(REG_SHAPE_A, sa);
      write_reg(REG_SHAPE_B, sb);
      write_reg(REG_STRIDE_A, {$urandom, $urandom});
      write_reg(REG_STRIDE_B, {$urandom, $urandom});
      write_reg(REG_BASE_A, {$urandom, $urandom});
      write_reg(REG_BASE_B, {$urandom, $urandom});
   endtask

   initial begin
      addr_result_type probe, none;
      logic [IDX_W-1:0] idx;
      logic [63:0] rnd;
      logic op;
      cycles = 0;
      mismatches = 0;
      calm = 1'b0;
      hold_req = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operand = 1'b0;
      req_flat_index = '0;
      csr_we = 1'b0;
      csr_index = REG_OPERAND_COUNT;
      csr_wdata = '0;
      op_count = 2'd1;
      shapes[0] = RESET_SHAPE;
      shapes[1] = RESET_SHAPE;
      strides[0] = '0;
      strides[1] = '0;
      bases[0] = '0;
      bases[1] = '0;
      none = '{default: '0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);

      add_row(item_row(1'b0, '0, 1, '0, 64'd1, ST_OK));
      add_row(item_row(1'b1, '0, 1, '0, 64'd1, ST_RANGE));
      add_row(item_row(1'b0, '1, 1, '0, 64'd1, ST_RANGE));
      add_row(cfg_row(REG_OPERAND_COUNT, 64'd2));
      add_row(cfg_row(REG_SHAPE_A, 64'h0005_0001_0003_0004));
      add_row(cfg_row(REG_SHAPE_B, 64'h0001_0002_0003_0001));
      add_row(cfg_row(REG_STRIDE_A, '1));
      add_row(cfg_row(REG_STRIDE_B, 64'h0011_0022_0033_0044));
      add_row(cfg_row(REG_BASE_A, 64'hFFFF_FFFF));
      add_row(cfg_row(REG_BASE_B, 64'h1234_5678));
      add_row(item_row(1'b0, '0, 0, '0, '0, ST_OK));
      add_row(item_row(1'b1, '0, 0, '0, '0, ST_OK));
      add_row(item_row(1'b0, 63'd119, 0, '0, '0, ST_OK));
      add_row(item_row(1'b1, 63'd119, 0, '0, '0, ST_OK));
      add_row(item_row(1'b1, 63'd57, 0, '0, '0, ST_OK));
      add_row(item_row(1'b0, 63'd120, 1, '0, 64'd120, ST_RANGE));
      add_row(cfg_row(REG_OPERAND_COUNT, 64'd0));
      add_row(item_row(1'b1, '0, 1, '0, 64'd60, ST_RANGE));
      add_row(item_row(1'b0, 63'd59, 0, '0, '0, ST_OK));
      add_row(cfg_row(REG_OPERAND_COUNT, 64'd3));
      add_row(item_row(1'b1, 63'd5, 0, '0, '0, ST_OK));
      add_row(cfg_row(REG_SHAPE_B, 64'h0001_0001_0007_0001));
      add_row(item_row(1'b1, '1, 1, '0, '0, ST_SHAPE));
      add_row(cfg_row(REG_SHAPE_B, 64'h0001_0000_0001_0001));
      add_row(item_row(1'b0, '0, 1, '0, '0, ST_RANGE));
      add_row(cfg_row(REG_SHAPE_A, '1));
      add_row(cfg_row(REG_SHAPE_B, '1));
      add_row(cfg_row(REG_STRIDE_B, '1));
      add_row(item_row(1'b0, '1, 0, '0, '0, ST_OK));
      add_row(item_row(1'b1, '1, 0, '0, '0, ST_OK));
      add_row(item_row(1'b0, '0, 0, '0, '0, ST_OK));

      foreach (rows[i]) begin
         if (rows[i].cfg) begin
            drain_items();
            write_reg(rows[i].reg_id, rows[i].value);
            repeat (SETTLE_CYCLES) @(negedge clock);
         end else begin
            send_item(rows[i].operand, rows[i].index, rows[i].typed, rows[i].result);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_items();
         random_config();
         repeat (SETTLE_CYCLES) @(negedge clock);
         if (ph == 1) hold_req = 1'b1;
         if (ph == RAND_PHASES - 1) calm = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            op = ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
            if ($urandom_range(0, 1) == 0) op = ~op;
            predict_addr(op, '0, probe);
            rnd = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: idx = rnd[62:0];
               1: idx = (probe.count == 0) ? rnd[62:0] : IDX_W'(probe.count - 64'd1);
               2: idx = IDX_W'(probe.count);
               default:
                  idx = (probe.count == 0 || probe.count[63]) ? rnd[62:0]
                                                                : IDX_W'(rnd % probe.count);
            endcase
            send_item(op, idx, 0, none);
         end
      end
      req_valid <= 1'b0;
      while (pending_addrs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/bso_pkg.sv
rtl/bso_shape.sv
rtl/bso_dim.sv
rtl/broadcast_strided_offset.sv
tb/tb.sv
